[rtl/hid_report_field_accumulator_macros.svh]
// Assertion macros used by the report field accumulator RTL.
`ifndef HID_REPORT_FIELD_ACCUMULATOR_MACROS_SVH
`define HID_REPORT_FIELD_ACCUMULATOR_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
// The enclosing module must have clk_i and rst_ni.
`define HRFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define HRFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hrfa_pkg.sv]
// Shared types and constants of the HID report field accumulator.
`timescale 1ns / 1ps

package hrfa_pkg;

  // Report and field geometry.
  localparam int ReportBits   = 64;
  localparam int PackedFields = 4;
  localparam int NumCtrlDef   = 4;
  localparam int OffW         = 6;
  localparam int SizeW        = 5;
  localparam int GainW        = 8;
  localparam int ValW         = 16;
  localparam int ByteW        = 8;
  localparam int ByteSelW     = 3;
  localparam int RawW         = 31;
  localparam int DeltaW       = 32;
  localparam int ProdW        = DeltaW + GainW + 1;
  localparam int SumW         = ProdW + 1;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFieldOffsets = 3'd0,
    CfgFieldSizes   = 3'd1,
    CfgGain         = 3'd2,
    CfgButtonOffset = 3'd3,
    CfgButtonsEn    = 3'd4
  } cfg_idx_e;

  // Pipeline control handed from the merge stage to the lanes.
  typedef struct packed {
    logic s1_load;  // a beat enters the product stage
    logic commit;   // the product stage item is folded into the stored values
  } hrfa_ctl_t;

endpackage

[rtl/hid_report_field_accumulator.sv]
// Top level of the HID report field accumulator.
//
// Each input beat on the s_axis channel carries the first 64 bits of a HID
// input report. Up to four control lanes extract their configured bit field,
// scale it by the gain and add it to a stored 16-bit value that clamps at
// 0 and 65535; a button byte may also be captured. Every report yields one
// output beat on m_axis with the four stored values, the button byte and a
// mask of the controls that were updated.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must write it only while no report is in flight, which the block
// does not enforce. A write to an unknown index is ignored. The accepting
// edge loads the product stage, and the stored values and the result beat
// update as that item moves on to the output slot. Throughput is one
// report per cycle while m_axis_tready is high; the loop that sets it is
// the add and clamp on the stored values. Reset clears the stored values,
// button byte, update mask, valid flags and configuration, with the gain
// set to 1. When the receiver stalls, the result beat holds and one more
// report can enter an empty product stage before s_axis_tready falls.
`timescale 1ns / 1ps

module hid_report_field_accumulator
  import hrfa_pkg::*;
#(
  parameter int NUM_CONTROLS = NumCtrlDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Report input: tdata = report_data[63:0].
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,
  // Result output: tdata = value_0[15:0], value_1[31:16], value_2[47:32],
  // value_3[63:48], button_bits[71:64], updated_mask[75:72], zero[79:76].
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [79:0]         m_axis_tdata
);

  localparam int NumLanes = (NUM_CONTROLS < PackedFields) ? NUM_CONTROLS : PackedFields;

  logic [OffW*PackedFields-1:0]  offsets_q;
  logic [SizeW*PackedFields-1:0] sizes_q;
  logic [GainW-1:0]              gain_q;
  logic [OffW-1:0]               btn_off_q;
  logic                          btn_en_q;
  hrfa_ctl_t                     ctl;
  logic [PackedFields-1:0]       upd;
  logic [ValW-1:0]               values [PackedFields];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q <= '0;
      sizes_q   <= '0;
      gain_q    <= GainW'(1);
      btn_off_q <= '0;
      btn_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFieldOffsets: offsets_q <= cfg_wdata_i[OffW*PackedFields-1:0];
        CfgFieldSizes:   sizes_q   <= cfg_wdata_i[SizeW*PackedFields-1:0];
        CfgGain:         gain_q    <= cfg_wdata_i[GainW-1:0];
        CfgButtonOffset: btn_off_q <= cfg_wdata_i[OffW-1:0];
        CfgButtonsEn:    btn_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control lanes; slots without a lane read zero and never update.
  for (genvar i = 0; i < PackedFields; i++) begin : g_lane
    if (i < NumLanes) begin : g_on
      hrfa_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .report_i (s_axis_tdata),
        .off_i    (offsets_q[OffW*i +: OffW]),
        .size_i   (sizes_q[SizeW*i +: SizeW]),
        .gain_i   (gain_q),
        .upd_o    (upd[i]),
        .value_o  (values[i])
      );
    end else begin : g_off
      assign upd[i]    = 1'b0;
      assign values[i] = '0;
    end
  end

  // Flow control, button capture and output beat.
  hrfa_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .report_i    (s_axis_tdata),
    .btn_sel_i   (btn_off_q[OffW-1 -: ByteSelW]),
    .btn_en_i    (btn_en_q),
    .upd_i       (upd),
    .values_i    (values),
    .ctl_o       (ctl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[rtl/hrfa_lane.sv]
// One control lane: field extraction, gain multiply and saturating accumulation.
`timescale 1ns / 1ps

module hrfa_lane
  import hrfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hrfa_ctl_t             ctl_i,
  input  logic [ReportBits-1:0] report_i,
  input  logic [OffW-1:0]       off_i,
  input  logic [SizeW-1:0]      size_i,
  input  logic [GainW-1:0]      gain_i,
  output logic                  upd_o,
  output logic [ValW-1:0]       value_o
);

  logic                     en;
  logic                     field_ok;
  logic                     is_signed;
  logic [OffW:0]            field_end;
  logic [ReportBits-1:0]    shifted;
  logic [RawW-1:0]          raw_mask;
  logic [RawW-1:0]          raw;
  logic [DeltaW-1:0]        delta_u;
  logic signed [DeltaW-1:0] delta;
  logic signed [ProdW-1:0]  prod_d, prod_q;
  logic                     en_q;
  logic signed [SumW-1:0]   sum;
  logic [ValW-1:0]          value_d, value_q;

  // A control with both offset and size at zero is switched off.
  assign en        = (off_i != '0) || (size_i != '0);
  assign field_end = {1'b0, off_i} + {2'b0, size_i};
  assign field_ok  = (field_end <= 7'(ReportBits));
  assign is_signed = (size_i == 5'd8) || (size_i == 5'd12) || (size_i == 5'd16);

  // Bit field extraction; a size of 31 gives an all-ones mask by wrap-around.
  assign shifted  = report_i >> off_i;
  assign raw_mask = (RawW'(1) << size_i) - RawW'(1);
  assign raw      = shifted[RawW-1:0] & raw_mask;

  // Two's complement sizes are sign-extended, the rest zero-extended.
  always_comb begin
    delta_u = {1'b0, raw};
    if (!field_ok) begin
      delta_u = '0;
    end else if (is_signed && raw[size_i - 5'd1]) begin
      delta_u = {1'b0, raw} - (DeltaW'(1) << size_i);
    end
  end
  assign delta  = $signed(delta_u);
  assign prod_d = delta * $signed({1'b0, gain_i});

  // Product stage register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_load) begin
      prod_q <= prod_d;
      en_q   <= en;
    end
  end

  // Accumulate and clamp to the unsigned 16-bit range.
  assign sum = {{(SumW-ProdW){prod_q[ProdW-1]}}, prod_q} + {{(SumW-ValW){1'b0}}, value_q};

  always_comb begin
    if (sum[SumW-1]) begin
      value_d = '0;
    end else if (|sum[SumW-2:ValW]) begin
      value_d = '1;
    end else begin
      value_d = sum[ValW-1:0];
    end
  end

  // Stored control value; it doubles as the output payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (ctl_i.commit && en_q) begin
      value_q <= value_d;
    end
  end

  assign upd_o   = en_q;
  assign value_o = value_q;

endmodule

[rtl/hrfa_merge.sv]
// Merge stage: beat flow control, button capture, update mask and output beat.
`timescale 1ns / 1ps

`include "hid_report_field_accumulator_macros.svh"

module hrfa_merge
  import hrfa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ReportBits-1:0]   report_i,
  input  logic [ByteSelW-1:0]     btn_sel_i,
  input  logic                    btn_en_i,
  input  logic [PackedFields-1:0] upd_i,
  input  logic [ValW-1:0]         values_i [PackedFields],
  output hrfa_ctl_t               ctl_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [79:0]             out_data_o
);

  logic                    s1_valid_q;
  logic                    out_valid_q;
  logic                    out_adv;
  logic [ByteW-1:0]        btn_byte_q;
  logic                    btn_en_q;
  logic [ByteW-1:0]        button_q;
  logic [PackedFields-1:0] mask_q;
  hrfa_ctl_t               ctl;

  // The output slot frees when empty or taken; stage one frees when it can move on.
  assign out_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || out_adv;
  assign ctl.s1_load = in_valid_i && in_ready_o;
  assign ctl.commit  = s1_valid_q && out_adv;
  assign ctl_o       = ctl;

  // Valid flags of the product stage and the output slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Button byte chosen by the byte part of the bit offset.
  always_ff @(posedge clk_i) begin
    if (ctl.s1_load) begin
      btn_byte_q <= report_i[{btn_sel_i, 3'b000} +: ByteW];
      btn_en_q   <= btn_en_i;
    end
  end

  // Stored button state and update mask of the last committed report.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_q <= '0;
      mask_q   <= '0;
    end else if (ctl.commit) begin
      if (btn_en_q) begin
        button_q <= btn_byte_q;
      end
      mask_q <= upd_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'b0000, mask_q, button_q,
                        values_i[3], values_i[2], values_i[1], values_i[0]};

  // Checks on the merge stage.
  `HRFA_ASSERT_IMP(a_commit_has_item, ctl.commit, s1_valid_q,
                   "commit without an item in the product stage")
  `HRFA_ASSERT_IMP(a_load_needs_room, ctl.s1_load && s1_valid_q, out_adv,
                   "product stage overwritten while its item is stalled")
  `HRFA_ASSERT_NXT(a_mask_holds, !ctl.commit, $stable(mask_q),
                   "update mask changed without a commit")
  `HRFA_ASSERT_NXT(a_button_holds, !ctl.commit, $stable(button_q),
                   "button state changed without a commit")

endmodule
